/* rtl/clt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the client lockout table
// Command and family codes, register indexes, reset values and the packed
// layout of one table entry, one request and the register set.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int SLOT_W          = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [1:0] CMD_CHECK   = 2'd0;
    localparam logic [1:0] CMD_FAIL    = 2'd1;
    localparam logic [1:0] CMD_SUCCESS = 2'd2;

    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ATTEMPTS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEVEL       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCKOUT_SECONDS = 2'd2;

    localparam logic [15:0] MAX_ATTEMPTS_RST    = 16'd5;
    localparam logic [15:0] MAX_LEVEL_RST       = 16'd8;
    localparam logic [31:0] LOCKOUT_SECONDS_RST = 32'd60;

    typedef struct packed {
        logic [1:0]  family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [31:0] last_access;
        logic        locked;
        logic [31:0] lock_until;
        logic [15:0] fails;
        logic [15:0] level;
    } entry_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [31:0] timestamp;
    } req_t;

    typedef struct packed {
        logic [15:0] max_attempts;
        logic [15:0] max_level;
        logic [31:0] lockout_seconds;
    } cfg_t;

endpackage

/* rtl/clt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module clt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/clt_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_scan: address match and LRU search unit
// Takes one entry per cycle while cmp_en is high; keeps the first match, the
// first free entry and the least recently used entry seen so far.
// ----------------------------------------------------------------------------
module clt_scan #(
    parameter int IDX_W = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmp_en,
    input  logic [IDX_W-1:0]    cmp_idx,
    input  logic                cmp_valid,
    input  clt_pkg::entry_t     cmp_entry,
    input  clt_pkg::req_t       req,
    output logic                found,
    output logic [IDX_W-1:0]    sel
);

    logic             found_reg;
    logic             have_free_reg;
    logic [IDX_W-1:0] sel_reg;
    logic [IDX_W-1:0] victim_reg;
    logic [31:0]      victim_last_reg;
    logic             match;
    logic             addr_eq;

    always_comb
    begin
        case (req.family)
            clt_pkg::FAM_IPV4: addr_eq = cmp_entry.addr_low[31:0] == req.addr_low[31:0];
            clt_pkg::FAM_IPV6: addr_eq = (cmp_entry.addr_high == req.addr_high) &&
                                         (cmp_entry.addr_low == req.addr_low);
            default:           addr_eq = 1'b0;
        endcase
        match = cmp_valid && (cmp_entry.family == req.family) && addr_eq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            have_free_reg <= 1'b0;
        end
        else if (start)
        begin
            found_reg     <= 1'b0;
            have_free_reg <= 1'b0;
        end
        else if (cmp_en && !found_reg)
        begin
            if (match)
            begin
                found_reg <= 1'b1;
            end
            else if (!cmp_valid)
            begin
                have_free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_en && !found_reg)
        begin
            if (match || (!cmp_valid && !have_free_reg))
            begin
                sel_reg <= cmp_idx;
            end
            // strict compare keeps the lowest index on ties
            if (!match && ((cmp_idx == '0) || (cmp_entry.last_access < victim_last_reg)))
            begin
                victim_reg      <= cmp_idx;
                victim_last_reg <= cmp_entry.last_access;
            end
        end
    end

    assign found = found_reg;
    assign sel   = (found_reg || have_free_reg) ? sel_reg : victim_reg;

endmodule

/* rtl/clt_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_update: command unit of the lockout table
// Applies check, fail or success to one entry; the lock length product is
// registered before the final entry is formed.
// ----------------------------------------------------------------------------
module clt_update (
    input  logic            clk,
    input  logic            mul_en,
    input  clt_pkg::entry_t cur,
    input  clt_pkg::req_t   req,
    input  clt_pkg::cfg_t   cfg,
    output clt_pkg::entry_t nxt,
    output logic            blocked
);

    logic [16:0] fails_inc;
    logic        hit_limit;
    logic [15:0] level_new;
    logic [47:0] prod_full;
    logic [31:0] prod_reg;

    assign fails_inc = {1'b0, cur.fails} + 17'd1;
    assign hit_limit = fails_inc >= {1'b0, cfg.max_attempts};
    assign level_new = (hit_limit && (cur.level < cfg.max_level)) ? cur.level + 16'd1
                                                                   : cur.level;
    assign prod_full = {32'd0, level_new} * {16'd0, cfg.lockout_seconds};

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_full[31:0];
        end
    end

    always_comb
    begin
        nxt     = cur;
        blocked = 1'b0;
        case (req.cmd)
            clt_pkg::CMD_CHECK:
            begin
                if (cur.locked)
                begin
                    if (req.timestamp > cur.lock_until)
                    begin
                        nxt.locked     = 1'b0;
                        nxt.lock_until = '0;
                        nxt.fails      = '0;
                    end
                    else
                    begin
                        nxt.last_access = req.timestamp;
                        blocked         = 1'b1;
                    end
                end
            end
            clt_pkg::CMD_FAIL:
            begin
                nxt.last_access = req.timestamp;
                if (!hit_limit)
                begin
                    nxt.fails = fails_inc[15:0];
                end
                else
                begin
                    nxt.level      = level_new;
                    nxt.locked     = 1'b1;
                    nxt.fails      = '0;
                    nxt.lock_until = req.timestamp + prod_reg;
                end
            end
            clt_pkg::CMD_SUCCESS:
            begin
                nxt.locked     = 1'b0;
                nxt.lock_until = '0;
                nxt.fails      = '0;
                nxt.level      = '0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

/* rtl/client_lockout_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_lockout_table_core: failed-login lockout table with LRU replacement
// Looks a client address up, allocates or evicts on a miss, applies the
// command and returns the entry state.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream (one beat each), results leave on the m_
//   stream, one result beat per request. Registers are written on the cfg_
//   channel, which is always ready; write them only while the block is idle.
//   Each request scans the table one entry per cycle through the single read
//   port of the entry RAM, then reads the chosen entry back, forms the lock
//   length in the multiplier and writes the entry. s_tready is high only in
//   the idle state between requests, so a new request is taken only after the
//   previous one has been written. The result sits in an output register;
//   while the receiver stalls, a following request may be accepted and
//   scanned, and holds in its write step until the output register frees.
//   Reset clears all valid bits at once, so the table is empty right after
//   reset with no clearing pass, and loads the register reset values.
// ----------------------------------------------------------------------------
module client_lockout_table_core #(
    parameter int ENTRIES = clt_pkg::ENTRIES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [159:0]                    s_tdata,   // addr_high, addr_low, timestamp
    input  logic [3:0]                      s_tuser,   // cmd, addr_family
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // blocked, lock_until, fail_count, level, slot, new_entry, zero pad
    output logic [71:0]                     m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [clt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam int EW = $bits(clt_pkg::entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_LOAD,
        ST_MUL,
        ST_WRITE
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [IDX_W-1:0]       cnt_reg;
    logic                   cmp_vld_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic [ENTRIES-1:0]     valid_reg;
    logic                   m_tvalid_reg;
    logic [71:0]            m_tdata_reg;
    clt_pkg::req_t          req_reg;
    clt_pkg::entry_t        cur_reg;
    clt_pkg::cfg_t          cfg_reg;

    logic                   accept;
    logic                   out_free;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic                   ram_wr_en;
    logic [EW-1:0]          ram_rd_data;
    clt_pkg::entry_t        rd_entry;
    clt_pkg::entry_t        scan_entry;
    clt_pkg::entry_t        fresh_entry;
    clt_pkg::entry_t        upd_entry;
    logic                   upd_blocked;
    logic                   scan_found;
    logic [IDX_W-1:0]       scan_sel;
    logic [IDX_W+clt_pkg::SLOT_W-1:0] sel_ext;
    clt_pkg::req_t          req_in;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = state_reg == ST_IDLE;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign req_in.cmd       = s_tuser[1:0];
    assign req_in.family    = s_tuser[3:2];
    assign req_in.addr_high = s_tdata[63:0];
    assign req_in.addr_low  = s_tdata[127:64];
    assign req_in.timestamp = s_tdata[159:128];

    assign ram_rd_en   = (state_reg == ST_SCAN) || (state_reg == ST_FETCH);
    assign ram_rd_addr = (state_reg == ST_SCAN) ? cnt_reg : scan_sel;
    assign ram_wr_en   = (state_reg == ST_WRITE) && out_free;

    assign rd_entry   = clt_pkg::entry_t'(ram_rd_data);
    // an entry never written reads as cleared
    assign scan_entry = valid_reg[cmp_idx_reg] ? rd_entry : clt_pkg::entry_t'('0);

    always_comb
    begin
        fresh_entry             = '0;
        fresh_entry.family      = req_reg.family;
        fresh_entry.addr_high   = req_reg.addr_high;
        fresh_entry.addr_low    = req_reg.addr_low;
        fresh_entry.last_access = req_reg.timestamp;
    end

    assign sel_ext = {{clt_pkg::SLOT_W{1'b0}}, scan_sel};

    clt_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (scan_sel),
        .wr_data (upd_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    clt_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .cmp_en    (cmp_vld_reg),
        .cmp_idx   (cmp_idx_reg),
        .cmp_valid (valid_reg[cmp_idx_reg]),
        .cmp_entry (scan_entry),
        .req       (req_reg),
        .found     (scan_found),
        .sel       (scan_sel)
    );

    clt_update u_update (
        .clk     (clk),
        .mul_en  (state_reg == ST_MUL),
        .cur     (cur_reg),
        .req     (req_reg),
        .cfg     (cfg_reg),
        .nxt     (upd_entry),
        .blocked (upd_blocked)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SCAN;
            ST_SCAN:  if (cnt_reg == LAST_IDX) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_FETCH;
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_WRITE;
            ST_WRITE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            cfg_reg.max_attempts    <= clt_pkg::MAX_ATTEMPTS_RST;
            cfg_reg.max_level       <= clt_pkg::MAX_LEVEL_RST;
            cfg_reg.lockout_seconds <= clt_pkg::LOCKOUT_SECONDS_RST;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= state_reg == ST_SCAN;
            if (state_reg == ST_SCAN)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (ram_wr_en)
            begin
                valid_reg[scan_sel] <= 1'b1;
                m_tvalid_reg        <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    clt_pkg::CFG_MAX_ATTEMPTS:    cfg_reg.max_attempts    <= cfg_data[15:0];
                    clt_pkg::CFG_MAX_LEVEL:       cfg_reg.max_level       <= cfg_data[15:0];
                    clt_pkg::CFG_LOCKOUT_SECONDS: cfg_reg.lockout_seconds <= cfg_data;
                    default:                      cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cnt_reg;
        if (accept)
        begin
            req_reg <= req_in;
        end
        if (state_reg == ST_LOAD)
        begin
            cur_reg <= scan_found ? rd_entry : fresh_entry;
        end
        if (ram_wr_en)
        begin
            m_tdata_reg <= {2'b00, !scan_found, sel_ext[clt_pkg::SLOT_W-1:0],
                            upd_entry.level, upd_entry.fails, upd_entry.lock_until,
                            upd_blocked};
        end
    end

    // a new request is never taken on the cycle after one was accepted
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request accepted while another is in progress");

    // a miss with no free entry only happens on a full table
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) && !scan_found |-> !valid_reg[scan_sel] || (&valid_reg))
        else $error("eviction chosen while a free entry exists");

    // entries are never released outside reset
    a_valid_grow: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_reg) >= $past($countones(valid_reg)))
        else $error("valid entry lost");

    // a result appears only out of the write step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("result raised outside the write step");

endmodule

/* tb/sv/tb_client_lockout_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_client_lockout_table_core: self-checking bench of the client lockout table
// Drives login requests on the s_ stream and tracks every entry of the table
// in a local copy, predicting lookup, LRU eviction, lock and unlock for each
// request. Result beats on the m_ stream are compared field by field in order.
// A directed part covers lockout, expiry, address families and register
// extremes; random phases then run under several register settings, all but
// the last with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_client_lockout_table_core;

    import clt_pkg::*;

    localparam int          ENTRIES        = ENTRIES_DEFAULT;
    localparam int          DRAIN_CYCLES   = 3 * (ENTRIES + 5);
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam logic [1:0]  FAM_OTHER      = 2'd2;
    localparam logic [1:0]  FAM_RESERVED   = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int          POOL_MAX       = 24;

    // packed from the top bit down, so blocked lands in bit 0 as on m_tdata
    typedef struct packed {
        logic        new_entry;
        logic [3:0]  slot;
        logic [15:0] level;
        logic [15:0] fail_count;
        logic [31:0] lock_until;
        logic        blocked;
    } lockout_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [159:0]           s_tdata;
    logic [3:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [71:0]            m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // local copy of the table and the registers
    logic        slot_valid [ENTRIES];
    entry_t      slots [ENTRIES];
    logic [15:0] cur_max_attempts;
    logic [15:0] cur_max_level;
    logic [31:0] cur_lockout_seconds;

    lockout_result_t expected_verdicts [$];

    bit          tx_idle_en;
    bit          rx_idle_en;
    logic [31:0] stamp_now;
    int unsigned n_fail;
    int unsigned n_sent;
    int unsigned n_settings;
    int unsigned n_lockouts;
    int unsigned n_blocked;
    int unsigned n_evictions;

    client_lockout_table_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $error("timeout: %0d results still outstanding", expected_verdicts.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void clear_lockout_table();
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_valid[i] = 1'b0;
            slots[i]      = '0;
        end
        cur_max_attempts    = MAX_ATTEMPTS_RST;
        cur_max_level       = MAX_LEVEL_RST;
        cur_lockout_seconds = LOCKOUT_SECONDS_RST;
    endfunction

    function automatic lockout_result_t apply_lockout_rules(input req_t r);
        lockout_result_t res;
        int              sel;
        int              victim;
        bit              found;
        bit              have_free;
        bit              hit;
        logic [16:0]     fails_next;
        logic [63:0]     lock_len;
        sel       = 0;
        victim    = 0;
        found     = 1'b0;
        have_free = 1'b0;
        res       = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!found)
            begin
                hit = slot_valid[i] && slots[i].family == r.family &&
                      ((r.family == FAM_IPV4 &&
                        slots[i].addr_low[31:0] == r.addr_low[31:0]) ||
                       (r.family == FAM_IPV6 && slots[i].addr_high == r.addr_high &&
                        slots[i].addr_low == r.addr_low));
                if (hit)
                begin
                    sel   = i;
                    found = 1'b1;
                end
                else
                begin
                    if (!slot_valid[i] && !have_free)
                    begin
                        have_free = 1'b1;
                        sel       = i;
                    end
                    if (i == 0 || slots[i].last_access < slots[victim].last_access)
                        victim = i;
                end
            end
        end

        if (!found)
        begin
            if (!have_free)
            begin
                sel = victim;
                n_evictions++;
            end
            slot_valid[sel]        = 1'b1;
            slots[sel]             = '0;
            slots[sel].family      = r.family;
            slots[sel].addr_high   = r.addr_high;
            slots[sel].addr_low    = r.addr_low;
            slots[sel].last_access = r.timestamp;
            res.new_entry          = 1'b1;
        end

        case (r.cmd)
            CMD_CHECK:
            begin
                if (slots[sel].locked)
                begin
                    if (r.timestamp > slots[sel].lock_until)
                    begin
                        slots[sel].locked     = 1'b0;
                        slots[sel].lock_until = '0;
                        slots[sel].fails      = '0;
                    end
                    else
                    begin
                        slots[sel].last_access = r.timestamp;
                        res.blocked            = 1'b1;
                        n_blocked++;
                    end
                end
            end
            CMD_FAIL:
            begin
                fails_next             = {1'b0, slots[sel].fails} + 17'd1;
                slots[sel].last_access = r.timestamp;
                if (fails_next < {1'b0, cur_max_attempts})
                    slots[sel].fails = fails_next[15:0];
                else
                begin
                    if (slots[sel].level < cur_max_level)
                        slots[sel].level = slots[sel].level + 16'd1;
                    slots[sel].locked     = 1'b1;
                    slots[sel].fails      = '0;
                    lock_len              = 64'(slots[sel].level) * 64'(cur_lockout_seconds);
                    slots[sel].lock_until = r.timestamp + lock_len[31:0];
                    n_lockouts++;
                end
            end
            CMD_SUCCESS:
            begin
                slots[sel].locked     = 1'b0;
                slots[sel].lock_until = '0;
                slots[sel].fails      = '0;
                slots[sel].level      = '0;
            end
            default: ;
        endcase

        res.lock_until = slots[sel].lock_until;
        res.fail_count = slots[sel].fails;
        res.level      = slots[sel].level;
        res.slot       = sel[3:0];
        return res;
    endfunction

    function automatic req_t make_req(input logic [1:0] cmd, input logic [1:0] fam,
                                      input logic [63:0] hi, input logic [63:0] lo,
                                      input logic [31:0] ts);
        req_t r;
        r.cmd       = cmd;
        r.family    = fam;
        r.addr_high = hi;
        r.addr_low  = lo;
        r.timestamp = ts;
        return r;
    endfunction

    // mostly creeping time so locks expire, now and then a jump or a step back
    function automatic logic [31:0] next_stamp();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            stamp_now = stamp_now + $urandom_range(0, 8);
        else if (roll < 93)
            stamp_now = $urandom;
        else
            return stamp_now - $urandom_range(1, 30);
        return stamp_now;
    endfunction

    task automatic send_req(input req_t r);
        int gap;
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.timestamp, r.addr_low, r.addr_high};
        s_tuser  <= {r.family, r.cmd};
        do @(posedge clk); while (!s_tready);
        expected_verdicts.push_back(apply_lockout_rules(r));
        n_sent++;
    endtask

    // drop valid and hold until every result beat is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] attempts, input logic [15:0] level_cap,
                              input logic [31:0] secs);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [31:0]            val [4];
        int                     k;
        idx[0] = CFG_UNUSED_INDEX;
        val[0] = $urandom;
        idx[1] = CFG_MAX_ATTEMPTS;
        val[1] = {16'($urandom), attempts};
        idx[2] = CFG_MAX_LEVEL;
        val[2] = {16'($urandom), level_cap};
        idx[3] = CFG_LOCKOUT_SECONDS;
        val[3] = secs;
        wait_idle();
        // start at the unused index on some settings
        for (k = $urandom_range(0, 1); k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!cfg_ready);
            case (idx[k])
                CFG_MAX_ATTEMPTS:    cur_max_attempts    = val[k][15:0];
                CFG_MAX_LEVEL:       cur_max_level       = val[k][15:0];
                CFG_LOCKOUT_SECONDS: cur_lockout_seconds = val[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic test_lockout_cycle();
        logic [63:0] addr_a;
        addr_a = 64'h0000_0000_C0A8_0001;
        for (int t = 100; t < 105; t++)
            send_req(make_req(CMD_FAIL, FAM_IPV4, 64'd0, addr_a, t));
        send_req(make_req(CMD_CHECK, FAM_IPV4, 64'd0, addr_a, 32'd150));
        // upper address bits are ignored for IPv4; the lock has just passed
        send_req(make_req(CMD_CHECK, FAM_IPV4, 64'hFFFF_0000_1234_5678,
                          {32'hDEAD_BEEF, addr_a[31:0]}, 32'd165));
        send_req(make_req(CMD_UNUSED, FAM_IPV4, 64'd0, addr_a, 32'd166));
        send_req(make_req(CMD_FAIL, FAM_IPV4, 64'd0, addr_a, 32'd167));
        send_req(make_req(CMD_SUCCESS, FAM_IPV4, 64'd0, addr_a, 32'd168));
        send_req(make_req(CMD_CHECK, FAM_IPV4, 64'd0, addr_a, 32'd169));
        wait_idle();
    endtask

    task automatic test_address_families();
        send_req(make_req(CMD_FAIL, FAM_IPV6, '1, '1, 32'hFFFF_FFFF));
        send_req(make_req(CMD_FAIL, FAM_IPV6, '1, 64'hFFFF_FFFF_FFFF_FFFE, 32'd200));
        send_req(make_req(CMD_CHECK, FAM_IPV6, 64'h7FFF_FFFF_FFFF_FFFF, '1, 32'd201));
        send_req(make_req(CMD_FAIL, FAM_IPV6, '1, '1, 32'd202));
        // other families never match, even with identical addresses
        send_req(make_req(CMD_FAIL, FAM_OTHER, 64'hA5A5, 64'h5A5A, 32'd203));
        send_req(make_req(CMD_FAIL, FAM_OTHER, 64'hA5A5, 64'h5A5A, 32'd204));
        send_req(make_req(CMD_CHECK, FAM_RESERVED, 64'hA5A5, 64'h5A5A, 32'd0));
        send_req(make_req(CMD_CHECK, FAM_IPV4, '1, 64'd0, 32'd0));
        wait_idle();
    endtask

    task automatic test_register_extremes();
        logic [63:0] addr_b;
        addr_b = 64'h0000_0000_0A00_0002;
        // zero attempts: every failure locks; zero level cap keeps level at zero
        set_config(16'd0, 16'd0, 32'd7);
        send_req(make_req(CMD_FAIL, FAM_IPV4, 64'd0, addr_b, 32'd500));
        send_req(make_req(CMD_CHECK, FAM_IPV4, 64'd0, addr_b, 32'd500));
        send_req(make_req(CMD_CHECK, FAM_IPV4, 64'd0, addr_b, 32'd501));
        // lock end wraps past the top of the time range
        set_config(16'd1, 16'hFFFF, 32'hFFFF_FFFF);
        send_req(make_req(CMD_FAIL, FAM_IPV4, 64'd0, addr_b, 32'hFFFF_FFF0));
        send_req(make_req(CMD_FAIL, FAM_IPV4, 64'd0, addr_b, 32'hFFFF_FFF1));
        send_req(make_req(CMD_CHECK, FAM_IPV4, 64'd0, addr_b, 32'hFFFF_FFFF));
        wait_idle();
    endtask

    task automatic test_random_phase(input logic [15:0] attempts, input logic [15:0] level_cap,
                                     input logic [31:0] secs, input int n_items,
                                     input bit idle);
        logic [1:0]  pool_fam [POOL_MAX];
        logic [63:0] pool_hi  [POOL_MAX];
        logic [63:0] pool_lo  [POOL_MAX];
        int          pool_size;
        int          k;
        int          roll;
        req_t        r;
        set_config(attempts, level_cap, secs);
        tx_idle_en = idle;
        rx_idle_en = idle;
        stamp_now  = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FC00;
        // more clients than entries in most phases, so evictions happen
        pool_size = $urandom_range(10, POOL_MAX);
        for (k = 0; k < pool_size; k++)
        begin
            roll        = $urandom_range(0, 99);
            pool_fam[k] = roll < 45 ? FAM_IPV4 : roll < 90 ? FAM_IPV6 :
                          roll < 95 ? FAM_OTHER : FAM_RESERVED;
            pool_hi[k]  = {$urandom, $urandom};
            pool_lo[k]  = {$urandom, $urandom};
            // near misses: IPv6 neighbors that share one half
            if (k > 0 && pool_fam[k] == FAM_IPV6 && pool_fam[k-1] == FAM_IPV6 &&
                $urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 1))
                    pool_hi[k] = pool_hi[k-1];
                else
                    pool_lo[k] = pool_lo[k-1];
            end
        end
        repeat (n_items)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                k           = $urandom_range(0, pool_size - 1);
                r.family    = pool_fam[k];
                r.addr_high = pool_hi[k];
                r.addr_low  = pool_lo[k];
                if (r.family == FAM_IPV4 && $urandom_range(0, 1))
                begin
                    r.addr_high = {$urandom, $urandom};
                    r.addr_low  = {$urandom, pool_lo[k][31:0]};
                end
            end
            else
            begin
                r.family    = 2'($urandom);
                r.addr_high = {$urandom, $urandom};
                r.addr_low  = {$urandom, $urandom};
            end
            roll      = $urandom_range(0, 99);
            r.cmd     = roll < 45 ? CMD_FAIL : roll < 80 ? CMD_CHECK :
                        roll < 93 ? CMD_SUCCESS : CMD_UNUSED;
            r.timestamp = next_stamp();
            send_req(r);
        end
        wait_idle();
    endtask

    // result checker and receiver stalls
    initial
    begin
        lockout_result_t got;
        lockout_result_t want;
        int              rx_hold;
        rx_hold  = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = lockout_result_t'(m_tdata[69:0]);
                if (expected_verdicts.size() == 0)
                begin
                    $error("result beat with no request outstanding: %h", m_tdata);
                    n_fail++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.blocked !== want.blocked)
                    begin
                        $error("blocked: expected %0d, actual %0d", want.blocked, got.blocked);
                        n_fail++;
                    end
                    if (got.lock_until !== want.lock_until)
                    begin
                        $error("lock_until: expected %0h, actual %0h",
                               want.lock_until, got.lock_until);
                        n_fail++;
                    end
                    if (got.fail_count !== want.fail_count)
                    begin
                        $error("fail_count: expected %0d, actual %0d",
                               want.fail_count, got.fail_count);
                        n_fail++;
                    end
                    if (got.level !== want.level)
                    begin
                        $error("level: expected %0d, actual %0d", want.level, got.level);
                        n_fail++;
                    end
                    if (got.slot !== want.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", want.slot, got.slot);
                        n_fail++;
                    end
                    if (got.new_entry !== want.new_entry)
                    begin
                        $error("new_entry: expected %0d, actual %0d",
                               want.new_entry, got.new_entry);
                        n_fail++;
                    end
                    if (m_tdata[71:70] !== 2'b00)
                    begin
                        $error("pad: expected 0, actual %0b", m_tdata[71:70]);
                        n_fail++;
                    end
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                if (rx_hold == 0)
                    m_tready <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                rx_hold  = $urandom_range(1, 15);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        n_fail      = 0;
        n_sent      = 0;
        n_settings  = 0;
        n_lockouts  = 0;
        n_blocked   = 0;
        n_evictions = 0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        stamp_now   = '0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        clear_lockout_table();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lockout_cycle();
        test_address_families();
        test_register_extremes();
        test_random_phase(16'd3, 16'd4, 32'd10, 220, 1'b1);
        test_random_phase(16'd1, 16'hFFFF, 32'hFFFF_FFFF, 180, 1'b1);
        test_random_phase(16'd0, 16'd0, 32'd7, 150, 1'b1);
        test_random_phase(16'hFFFF, 16'd2, 32'd1, 120, 1'b1);
        test_random_phase(16'($urandom_range(1, 8)), 16'($urandom_range(0, 10)),
                          $urandom_range(0, 50), 250, 1'b1);
        test_random_phase(16'd2, 16'd3, 32'd5, 250, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d requests under %0d register settings, IPv4/IPv6/other families.",
                 n_sent, n_settings);
        $display("Saw %0d lockouts, %0d blocked checks and %0d LRU evictions.",
                 n_lockouts, n_blocked, n_evictions);
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/clt_pkg.sv
rtl/clt_ram.sv
rtl/clt_scan.sv
rtl/clt_update.sv
rtl/client_lockout_table_core.sv
tb/sv/tb_client_lockout_table_core.sv
